/* rtl/core/rwp_pkg.sv */
// Shared types and constants for the RIFF WAVE stream parser.
package rwp_pkg;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Classification of one input transfer.
    typedef enum logic
    {
        ITEM_BYTE = 1'b0,
        ITEM_EOF  = 1'b1
    } item_kind_t;

    // One classified input item as it travels through the queue.
    typedef struct packed
    {
        item_kind_t kind;
        logic [7:0] value;
    } item_t;

    // Parser phases.
    typedef enum logic [3:0]
    {
        PH_HEADER = 4'd0,
        PH_ID     = 4'd1,
        PH_SIZE   = 4'd2,
        PH_FMT    = 4'd3,
        PH_SKIP   = 4'd4,
        PH_DATA   = 4'd5,
        PH_DONE   = 4'd6
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_HEADER  = 2'd1;
    localparam logic [1:0] ERR_FORMAT  = 2'd2;
    localparam logic [1:0] ERR_NO_DATA = 2'd3;

    // Chunk tags, first byte in the top position.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Header and chunk layout.
    localparam logic [4:0]  POS_RIFF_END   = 5'd3;
    localparam logic [4:0]  POS_HEADER_END = 5'd11;
    localparam logic [4:0]  FIELD_BYTES    = 5'd4;
    localparam logic [4:0]  FMT_BODY_BYTES = 5'd16;
    localparam logic [31:0] FMT_BODY_LEN   = 32'd16;

    // Byte positions inside the fmt body where a field completes.
    localparam logic [4:0] FMT_POS_CODE     = 5'd1;
    localparam logic [4:0] FMT_POS_CHANNELS = 5'd3;
    localparam logic [4:0] FMT_POS_RATE     = 5'd7;
    localparam logic [4:0] FMT_POS_BITS     = 5'd15;

    // Sample conversion.
    localparam logic [15:0] SIGN_FLIP     = 16'h8000;
    localparam logic [15:0] BYTE_SAMPLE   = 16'd8;
    localparam logic [16:0] BITS_PER_BYTE = 17'd8;

endpackage

/* rtl/core/rwp_front.sv */
// Front end: input register that accepts and classifies each byte or end-of-file transfer.
module rwp_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     data_byte,
    input  logic           end_of_file,
    output logic           push_valid,
    input  logic           push_ready,
    output rwp_pkg::item_t push_item
);
    import rwp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    // The stage holds one item and refills in the same cycle that it drains.
    assign in_stall = valid_reg && !push_ready;
    assign accept   = in_valid && !in_stall;

    // Classify the transfer; an end-of-file item carries no byte.
    always_comb
    begin
        item_next  = item_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            if (end_of_file)
            begin
                item_next.kind  = ITEM_EOF;
                item_next.value = 8'h00;
            end
            else
            begin
                item_next.kind  = ITEM_BYTE;
                item_next.value = data_byte;
            end
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

/* rtl/core/rwp_fifo.sv */
// Short first-in first-out queue that decouples the front and back ends.
module rwp_fifo
#(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update, with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/rwp_back.sv */
// Back end: chunk parser state machine, sample assembly and the result register.
module rwp_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  rwp_pkg::item_t pop_item,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     kind,
    output logic [15:0]    sample,
    output logic [15:0]    channel,
    output logic           last_sample,
    output logic [1:0]     error_code,
    output logic [15:0]    format_tag,
    output logic [15:0]    channel_total,
    output logic [31:0]    rate_hz,
    output logic [15:0]    bits_per_sample,
    output logic [31:0]    data_bytes
);
    import rwp_pkg::*;

    // What the current item does, as decided by the datapath.
    typedef struct packed
    {
        logic       fail;
        logic [1:0] fail_code;
        logic       go_id;
        logic       go_size;
        logic       go_fmt;
        logic       go_skip;
        logic       go_data;
        logic       emit_sample;
        logic       last;
    } step_t;

    // Parser state.
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic [31:0] tag_reg;
    logic [31:0] tag_next;
    logic [31:0] accum_reg;
    logic [31:0] accum_next;
    logic [31:0] skip_reg;
    logic [31:0] skip_next;
    logic        seen_reg;
    logic        seen_next;
    logic [15:0] fmt_code_reg;
    logic [15:0] fmt_code_next;
    logic [15:0] chan_count_reg;
    logic [15:0] chan_count_next;
    logic [31:0] rate_reg;
    logic [31:0] rate_next;
    logic [15:0] bits_reg;
    logic [15:0] bits_next;
    logic [31:0] remain_reg;
    logic [31:0] remain_next;
    logic [15:0] sacc_reg;
    logic [15:0] sacc_next;
    logic [16:0] sbc_reg;
    logic [16:0] sbc_next;
    logic [15:0] chan_reg;
    logic [15:0] chan_next;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  kind_reg;
    logic [15:0] sample_reg;
    logic [15:0] channel_reg;
    logic        last_reg;
    logic [1:0]  error_reg;
    logic [15:0] format_reg;
    logic [15:0] total_reg;
    logic [31:0] rate_out_reg;
    logic [15:0] bits_out_reg;
    logic [31:0] bytes_out_reg;

    // Combinational result of the current item.
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [15:0] res_sample;
    logic [15:0] res_channel;
    logic        res_last;
    logic [1:0]  res_error;
    logic [15:0] res_format;
    logic [15:0] res_total;
    logic [31:0] res_rate;
    logic [15:0] res_bits;
    logic [31:0] res_bytes;

    step_t       step;
    logic        pop;
    logic        is_eof;
    logic [7:0]  in_byte;
    logic [31:0] tag_shift;
    logic [31:0] accum_shift;
    logic [15:0] sacc_shift;
    logic [4:0]  pos_inc;
    logic [31:0] skip_left;
    logic [31:0] remain_left;
    logic [16:0] sbc_sum;
    logic [16:0] chan_inc;

    // A new item is taken whenever the result register is free or draining.
    assign pop_ready   = !out_valid_reg || !out_stall;
    assign pop         = pop_valid && pop_ready;
    assign is_eof      = (pop_item.kind == ITEM_EOF);
    assign in_byte     = pop_item.value;
    assign tag_shift   = {tag_reg[23:0], in_byte};
    assign accum_shift = {in_byte, accum_reg[31:8]};
    assign sacc_shift  = {in_byte, sacc_reg[15:8]};
    assign pos_inc     = pos_reg + 5'd1;
    assign skip_left   = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;
    assign remain_left = (remain_reg != 32'd0) ? remain_reg - 32'd1 : remain_reg;
    assign sbc_sum     = sbc_reg + BITS_PER_BYTE;
    assign chan_inc    = {1'b0, chan_reg} + 17'd1;

    // Datapath: field capture, counters and the decision for this item.
    always_comb
    begin
        step            = '0;
        pos_next        = pos_reg;
        tag_next        = tag_reg;
        accum_next      = accum_reg;
        skip_next       = skip_reg;
        seen_next       = seen_reg;
        fmt_code_next   = fmt_code_reg;
        chan_count_next = chan_count_reg;
        rate_next       = rate_reg;
        bits_next       = bits_reg;
        remain_next     = remain_reg;
        sacc_next       = sacc_reg;
        sbc_next        = sbc_reg;
        chan_next       = chan_reg;
        if (pop && (phase_reg != PH_DONE))
        begin
            if (is_eof)
            begin
                step.fail = 1'b1;
                if (phase_reg == PH_HEADER)
                begin
                    step.fail_code = ERR_HEADER;
                end
                else if (phase_reg == PH_FMT)
                begin
                    step.fail_code = ERR_FORMAT;
                end
                else
                begin
                    step.fail_code = ERR_NO_DATA;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        tag_next = tag_shift;
                        if ((pos_reg == POS_RIFF_END) && (tag_shift != TAG_RIFF))
                        begin
                            step.fail      = 1'b1;
                            step.fail_code = ERR_HEADER;
                        end
                        else if (pos_reg >= POS_HEADER_END)
                        begin
                            if (tag_shift != TAG_WAVE)
                            begin
                                step.fail      = 1'b1;
                                step.fail_code = ERR_HEADER;
                            end
                            else
                            begin
                                pos_next   = '0;
                                step.go_id = 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    PH_ID:
                    begin
                        tag_next = tag_shift;
                        if (pos_inc >= FIELD_BYTES)
                        begin
                            pos_next = '0;
                            if ((tag_shift == TAG_DATA) && !seen_reg)
                            begin
                                step.fail      = 1'b1;
                                step.fail_code = ERR_FORMAT;
                            end
                            else
                            begin
                                accum_next   = '0;
                                step.go_size = 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    PH_SIZE:
                    begin
                        accum_next = accum_shift;
                        if (pos_inc < FIELD_BYTES)
                        begin
                            pos_next = pos_inc;
                        end
                        else
                        begin
                            pos_next = '0;
                            if (tag_reg == TAG_FMT)
                            begin
                                if (accum_shift < FMT_BODY_LEN)
                                begin
                                    step.fail      = 1'b1;
                                    step.fail_code = ERR_FORMAT;
                                end
                                else
                                begin
                                    skip_next   = accum_shift - FMT_BODY_LEN;
                                    step.go_fmt = 1'b1;
                                end
                            end
                            else if (tag_reg == TAG_DATA)
                            begin
                                if (accum_shift == 32'd0)
                                begin
                                    step.fail      = 1'b1;
                                    step.fail_code = ERR_NO_DATA;
                                end
                                else if (bits_reg == 16'd0)
                                begin
                                    step.fail      = 1'b1;
                                    step.fail_code = ERR_FORMAT;
                                end
                                else
                                begin
                                    remain_next  = accum_shift;
                                    chan_next    = '0;
                                    sacc_next    = '0;
                                    sbc_next     = '0;
                                    step.go_data = 1'b1;
                                end
                            end
                            else
                            begin
                                // Unknown chunk: count its body away, if any.
                                skip_next = accum_shift;
                                if (accum_shift != 32'd0)
                                begin
                                    step.go_skip = 1'b1;
                                end
                                else
                                begin
                                    step.go_id = 1'b1;
                                end
                            end
                        end
                    end
                    PH_FMT:
                    begin
                        accum_next = accum_shift;
                        case (pos_reg)
                            FMT_POS_CODE:     fmt_code_next   = accum_shift[31:16];
                            FMT_POS_CHANNELS: chan_count_next = accum_shift[31:16];
                            FMT_POS_RATE:     rate_next       = accum_shift;
                            FMT_POS_BITS:     bits_next       = accum_shift[31:16];
                            default:          ;
                        endcase
                        if (pos_inc >= FMT_BODY_BYTES)
                        begin
                            pos_next  = '0;
                            seen_next = 1'b1;
                            if (skip_reg != 32'd0)
                            begin
                                step.go_skip = 1'b1;
                            end
                            else
                            begin
                                step.go_id = 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_left;
                        if (skip_left == 32'd0)
                        begin
                            step.go_id = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        sacc_next   = sacc_shift;
                        sbc_next    = sbc_sum;
                        remain_next = remain_left;
                        if (!((sbc_sum < {1'b0, bits_reg}) && (remain_left != 32'd0)))
                        begin
                            step.emit_sample = 1'b1;
                            step.last        = (remain_left == 32'd0);
                            if (chan_inc >= {1'b0, chan_count_reg})
                            begin
                                chan_next = '0;
                            end
                            else
                            begin
                                chan_next = chan_inc[15:0];
                            end
                            sacc_next = '0;
                            sbc_next  = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step.fail)
        begin
            phase_next = PH_DONE;
        end
        else if (step.emit_sample && step.last)
        begin
            phase_next = PH_DONE;
        end
        else if (step.go_id)
        begin
            phase_next = PH_ID;
        end
        else if (step.go_size)
        begin
            phase_next = PH_SIZE;
        end
        else if (step.go_fmt)
        begin
            phase_next = PH_FMT;
        end
        else if (step.go_skip)
        begin
            phase_next = PH_SKIP;
        end
        else if (step.go_data)
        begin
            phase_next = PH_DATA;
        end
    end

    // Result fields; anything that does not apply to the kind stays zero.
    always_comb
    begin
        res_valid   = 1'b0;
        res_kind    = KIND_SAMPLE;
        res_sample  = '0;
        res_channel = '0;
        res_last    = 1'b0;
        res_error   = ERR_NONE;
        res_format  = '0;
        res_total   = '0;
        res_rate    = '0;
        res_bits    = '0;
        res_bytes   = '0;
        if (step.fail)
        begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_error = step.fail_code;
        end
        else if (step.go_data)
        begin
            res_valid  = 1'b1;
            res_kind   = KIND_FORMAT;
            res_format = fmt_code_reg;
            res_total  = chan_count_reg;
            res_rate   = rate_reg;
            res_bits   = bits_reg;
            res_bytes  = accum_shift;
        end
        else if (step.emit_sample)
        begin
            res_valid   = 1'b1;
            res_kind    = KIND_SAMPLE;
            res_sample  = (bits_reg <= BYTE_SAMPLE) ? (sacc_shift ^ SIGN_FLIP) : sacc_shift;
            res_channel = chan_reg;
            res_last    = step.last;
        end
    end

    // The result register drains on a transfer and refills from the current item.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            pos_reg        <= '0;
            tag_reg        <= '0;
            accum_reg      <= '0;
            skip_reg       <= '0;
            seen_reg       <= 1'b0;
            fmt_code_reg   <= '0;
            chan_count_reg <= '0;
            rate_reg       <= '0;
            bits_reg       <= '0;
            remain_reg     <= '0;
            sacc_reg       <= '0;
            sbc_reg        <= '0;
            chan_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            tag_reg        <= tag_next;
            accum_reg      <= accum_next;
            skip_reg       <= skip_next;
            seen_reg       <= seen_next;
            fmt_code_reg   <= fmt_code_next;
            chan_count_reg <= chan_count_next;
            rate_reg       <= rate_next;
            bits_reg       <= bits_next;
            remain_reg     <= remain_next;
            sacc_reg       <= sacc_next;
            sbc_reg        <= sbc_next;
            chan_reg       <= chan_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload, loaded only with a new result.
    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            kind_reg      <= res_kind;
            sample_reg    <= res_sample;
            channel_reg   <= res_channel;
            last_reg      <= res_last;
            error_reg     <= res_error;
            format_reg    <= res_format;
            total_reg     <= res_total;
            rate_out_reg  <= res_rate;
            bits_out_reg  <= res_bits;
            bytes_out_reg <= res_bytes;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign sample          = sample_reg;
    assign channel         = channel_reg;
    assign last_sample     = last_reg;
    assign error_code      = error_reg;
    assign format_tag      = format_reg;
    assign channel_total   = total_reg;
    assign rate_hz         = rate_out_reg;
    assign bits_per_sample = bits_out_reg;
    assign data_bytes      = bytes_out_reg;

    // Once finished, the parser never leaves the done phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("parser left the done phase");

    // A waiting result is never overwritten while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("item taken while a stalled result waits");

    // Samples come only from the data phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step.emit_sample) |-> (phase_reg == PH_DATA))
        else $error("sample produced outside the data chunk");

    // The header position never runs past the twelfth byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (pos_reg <= POS_HEADER_END))
        else $error("header byte position out of range");

endmodule

/* rtl/core/riff_wave_stream_parser.sv */
// Top level of the RIFF WAVE stream parser: front end, queue and back end.
//
// The parser takes one file byte, or an end-of-file marker, per transfer and sustains one
// transfer per clock cycle while in_stall is low; every byte is handled by an update of the
// parser state machine in the back end. When nothing stalls, a result (sample, format
// announcement or error) passes from its byte through the input register, the queue and
// the result register. The queue of QUEUE_DEPTH entries lets the input side keep taking
// bytes for a while when the output side stalls. After an error or the last sample of the
// data chunk, input is taken and dropped until reset.
module riff_wave_stream_parser
#(
    parameter int QUEUE_DEPTH = rwp_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] sample,
    output logic [15:0] channel,
    output logic        last_sample,
    output logic [1:0]  error_code,
    output logic [15:0] format_tag,
    output logic [15:0] channel_total,
    output logic [31:0] rate_hz,
    output logic [15:0] bits_per_sample,
    output logic [31:0] data_bytes
);
    import rwp_pkg::*;

    localparam int ITEM_W = $bits(item_t);

    logic              push_valid;
    logic              push_ready;
    item_t             push_item;
    logic              pop_valid;
    logic              pop_ready;
    logic [ITEM_W-1:0] pop_data;
    item_t             pop_item;

    assign pop_item = item_t'(pop_data);

    // Input register and classification.
    rwp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    // Queue between the two halves.
    rwp_fifo
    #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Parser and result register.
    rwp_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_item        (pop_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .sample          (sample),
        .channel         (channel),
        .last_sample     (last_sample),
        .error_code      (error_code),
        .format_tag      (format_tag),
        .channel_total   (channel_total),
        .rate_hz         (rate_hz),
        .bits_per_sample (bits_per_sample),
        .data_bytes      (data_bytes)
    );

endmodule

/* tb/riff_wave_stream_parser_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the RIFF WAVE stream parser, driving one generated WAV stream.
module riff_wave_stream_parser_tb;
    import rwp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_FROM   = 420;
    localparam int QUIET_TO     = 560;
    localparam int DRAIN_CYCLES = 30;
    localparam int REPORT_MAX   = 10;

    // One result as the block presents it; fields that do not apply are zero.
    typedef struct packed
    {
        logic [1:0]  kind;
        logic [15:0] sample;
        logic [15:0] channel;
        logic        last;
        logic [1:0]  err;
        logic [15:0] fmt;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] len;
    } wav_result_t;

    // A row of the directed table; typed_none rows are known to give no result.
    typedef struct packed
    {
        bit         typed_none;
        logic       eof;
        logic [7:0] value;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        end_of_file;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [15:0] channel;
    logic        last_sample;
    logic [1:0]  error_code;
    logic [15:0] format_tag;
    logic [15:0] channel_total;
    logic [31:0] rate_hz;
    logic [15:0] bits_per_sample;
    logic [31:0] data_bytes;

    // Parser state mirrored by the predictor.
    phase_t      pr_phase;
    logic [4:0]  pr_pos;
    logic [31:0] pr_tag;
    logic [31:0] pr_acc;
    logic [31:0] pr_skip;
    bit          pr_fmt_seen;
    logic [15:0] pr_code;
    logic [15:0] pr_chans;
    logic [31:0] pr_rate;
    logic [15:0] pr_bits;
    logic [31:0] pr_left;
    logic [15:0] pr_smp;
    logic [16:0] pr_smp_bits;
    logic [15:0] pr_chan;

    wav_result_t awaited_results[$];
    bit          in_take;
    bit          quiet;
    bit          hold_done;
    int          hold_left;
    int          in_count;
    int          cycles;
    int          checked;
    int          mismatches;
    int          n_samples;
    int          n_formats;
    int          n_errors;

    // Header with extreme size bytes, then an empty chunk of unknown type.
    stim_row_t directed_rows [20] = '{
        {1'b1, 1'b0, "R"}, {1'b1, 1'b0, "I"}, {1'b1, 1'b0, "F"}, {1'b1, 1'b0, "F"},
        {1'b1, 1'b0, 8'hFF}, {1'b1, 1'b0, 8'h00}, {1'b1, 1'b0, 8'hFF}, {1'b1, 1'b0, 8'h00},
        {1'b1, 1'b0, "W"}, {1'b1, 1'b0, "A"}, {1'b1, 1'b0, "V"}, {1'b1, 1'b0, "E"},
        {1'b0, 1'b0, "J"}, {1'b0, 1'b0, "U"}, {1'b0, 1'b0, "N"}, {1'b0, 1'b0, "K"},
        {1'b0, 1'b0, 8'h00}, {1'b0, 1'b0, 8'h00}, {1'b0, 1'b0, 8'h00}, {1'b0, 1'b0, 8'h00}
    };

    riff_wave_stream_parser u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_file     (end_of_file),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .sample          (sample),
        .channel         (channel),
        .last_sample     (last_sample),
        .error_code      (error_code),
        .format_tag      (format_tag),
        .channel_total   (channel_total),
        .rate_hz         (rate_hz),
        .bits_per_sample (bits_per_sample),
        .data_bytes      (data_bytes)
    );

    // Clock.
    always #1 clk = ~clk;

    // Terminal error: the parser drops everything afterwards.
    function automatic bit parse_fail(input logic [1:0] code, output wav_result_t r);
        r = '0;
        r.kind = KIND_ERROR;
        r.err = code;
        pr_phase = PH_DONE;
        return 1'b1;
    endfunction

    // Advance the parser by one byte or end-of-file; returns 1 when a result is due.
    function automatic bit parse_byte(input logic [7:0] b, input logic eof,
                                      output wav_result_t r);
        logic [31:0] size;
        logic [16:0] next_chan;
        r = '0;
        if (pr_phase == PH_DONE)
            return 1'b0;
        if (eof)
        begin
            if (pr_phase == PH_HEADER)
                return parse_fail(ERR_HEADER, r);
            if (pr_phase == PH_FMT)
                return parse_fail(ERR_FORMAT, r);
            return parse_fail(ERR_NO_DATA, r);
        end
        case (pr_phase)
            PH_HEADER:
            begin
                pr_tag = {pr_tag[23:0], b};
                if (pr_pos == POS_RIFF_END && pr_tag != TAG_RIFF)
                    return parse_fail(ERR_HEADER, r);
                if (pr_pos >= POS_HEADER_END)
                begin
                    if (pr_tag != TAG_WAVE)
                        return parse_fail(ERR_HEADER, r);
                    pr_pos = '0;
                    pr_phase = PH_ID;
                end
                else
                    pr_pos = pr_pos + 5'd1;
            end
            PH_ID:
            begin
                pr_tag = {pr_tag[23:0], b};
                pr_pos = pr_pos + 5'd1;
                if (pr_pos >= FIELD_BYTES)
                begin
                    pr_pos = '0;
                    if (pr_tag == TAG_DATA && !pr_fmt_seen)
                        return parse_fail(ERR_FORMAT, r);
                    pr_acc = '0;
                    pr_phase = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                pr_acc = {b, pr_acc[31:8]};
                pr_pos = pr_pos + 5'd1;
                if (pr_pos < FIELD_BYTES)
                    return 1'b0;
                pr_pos = '0;
                size = pr_acc;
                if (pr_tag == TAG_FMT)
                begin
                    if (size < FMT_BODY_LEN)
                        return parse_fail(ERR_FORMAT, r);
                    pr_skip = size - FMT_BODY_LEN;
                    pr_phase = PH_FMT;
                    return 1'b0;
                end
                if (pr_tag == TAG_DATA)
                begin
                    if (size == 0)
                        return parse_fail(ERR_NO_DATA, r);
                    if (pr_bits == 0)
                        return parse_fail(ERR_FORMAT, r);
                    pr_left = size;
                    pr_chan = '0;
                    pr_smp = '0;
                    pr_smp_bits = '0;
                    pr_phase = PH_DATA;
                    r.kind = KIND_FORMAT;
                    r.fmt = pr_code;
                    r.chans = pr_chans;
                    r.rate = pr_rate;
                    r.bits = pr_bits;
                    r.len = size;
                    return 1'b1;
                end
                pr_skip = size;
                pr_phase = (size != 0) ? PH_SKIP : PH_ID;
            end
            PH_FMT:
            begin
                pr_acc = {b, pr_acc[31:8]};
                case (pr_pos)
                    FMT_POS_CODE:     pr_code = pr_acc[31:16];
                    FMT_POS_CHANNELS: pr_chans = pr_acc[31:16];
                    FMT_POS_RATE:     pr_rate = pr_acc;
                    FMT_POS_BITS:     pr_bits = pr_acc[31:16];
                    default:          ;
                endcase
                pr_pos = pr_pos + 5'd1;
                if (pr_pos >= FMT_BODY_BYTES)
                begin
                    pr_pos = '0;
                    pr_fmt_seen = 1'b1;
                    pr_phase = (pr_skip != 0) ? PH_SKIP : PH_ID;
                end
            end
            PH_SKIP:
            begin
                if (pr_skip != 0)
                    pr_skip = pr_skip - 32'd1;
                if (pr_skip == 0)
                    pr_phase = PH_ID;
            end
            PH_DATA:
            begin
                // Bytes enter at the top, so only the last two bytes of a sample survive.
                pr_smp = {b, pr_smp[15:8]};
                pr_smp_bits = pr_smp_bits + BITS_PER_BYTE;
                if (pr_left != 0)
                    pr_left = pr_left - 32'd1;
                if (pr_smp_bits < pr_bits && pr_left != 0)
                    return 1'b0;
                r.kind = KIND_SAMPLE;
                r.sample = (pr_bits <= BYTE_SAMPLE) ? (pr_smp ^ SIGN_FLIP) : pr_smp;
                r.channel = pr_chan;
                r.last = (pr_left == 0);
                next_chan = {1'b0, pr_chan} + 17'd1;
                pr_chan = (next_chan >= {1'b0, pr_chans}) ? 16'd0 : next_chan[15:0];
                pr_smp = '0;
                pr_smp_bits = '0;
                if (pr_left == 0)
                    pr_phase = PH_DONE;
                return 1'b1;
            end
            default:
                pr_phase = PH_DONE;
        endcase
        return 1'b0;
    endfunction

    function automatic string res_text(input wav_result_t r);
        return $sformatf({"kind=%0d sample=%h chan=%0d last=%0b err=%0d fmt=%h chans=%0d ",
                          "rate=%0d bits=%0d len=%0d"}, r.kind, r.sample, r.channel, r.last,
                         r.err, r.fmt, r.chans, r.rate, r.bits, r.len);
    endfunction

    // Offer one item after a random gap and wait for the transfer.
    task automatic put_byte(input logic [7:0] b, input logic eof, input bit by_model);
        wav_result_t r;
        bit          due;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_file <= eof;
        do @(posedge clk); while (!in_take);
        in_count++;
        quiet = (in_count >= QUIET_FROM && in_count < QUIET_TO);
        due = parse_byte(b, eof, r);
        if (due && by_model)
            awaited_results.push_back(r);
    endtask

    task automatic put_le16(input logic [15:0] v);
        put_byte(v[7:0], 1'b0, 1'b1);
        put_byte(v[15:8], 1'b0, 1'b1);
    endtask

    task automatic put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endtask

    // Chunk tags go out first character first.
    task automatic put_tag(input logic [31:0] t);
        put_byte(t[31:24], 1'b0, 1'b1);
        put_byte(t[23:16], 1'b0, 1'b1);
        put_byte(t[15:8], 1'b0, 1'b1);
        put_byte(t[7:0], 1'b0, 1'b1);
    endtask

    task automatic put_junk_chunk(input int len);
        logic [31:0] id;
        do id = $urandom; while (id == TAG_FMT || id == TAG_DATA);
        put_tag(id);
        put_le32(len);
        repeat (len) put_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // fmt chunk with random byte rate and block align, plus extra trailing bytes.
    task automatic put_fmt_chunk(input logic [15:0] code, input logic [15:0] chans,
                                 input logic [31:0] rate, input logic [15:0] bits,
                                 input int extra);
        put_tag(TAG_FMT);
        put_le32(FMT_BODY_LEN + extra);
        put_le16(code);
        put_le16(chans);
        put_le32(rate);
        put_le32($urandom);
        put_le16(16'($urandom_range(65535)));
        put_le16(bits);
        repeat (extra) put_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && in_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Mid-cycle sampling: handshakes and payloads are settled here.
    always @(negedge clk)
    begin : result_check
        wav_result_t seen;
        wav_result_t want;
        in_take = in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {kind, sample, channel, last_sample, error_code, format_tag,
                    channel_total, rate_hz, bits_per_sample, data_bytes};
            if (seen.kind == KIND_SAMPLE)
                n_samples++;
            else if (seen.kind == KIND_FORMAT)
                n_formats++;
            else
                n_errors++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected result transfer: %s", res_text(seen));
            end
            else
            begin
                want = awaited_results.pop_front();
                checked++;
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("Mismatch on result %0d\n  expected %s\n  actual   %s",
                                 checked, res_text(want), res_text(seen));
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results still awaited.",
                     cycles, awaited_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: directed header, random chunk layout, random sample data, stream end.
    initial
    begin
        int          n_data;
        logic [31:0] data_len;
        logic [15:0] chans_cfg;
        logic [15:0] bits_cfg;
        bit          end_by_eof;

        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        end_of_file = 1'b0;
        pr_phase = PH_HEADER;
        pr_pos = '0;
        pr_tag = '0;
        pr_acc = '0;
        pr_skip = '0;
        pr_fmt_seen = 1'b0;
        pr_code = '0;
        pr_chans = '0;
        pr_rate = '0;
        pr_bits = '0;
        pr_left = '0;
        pr_smp = '0;
        pr_smp_bits = '0;
        pr_chan = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (directed_rows[i])
            put_byte(directed_rows[i].value, directed_rows[i].eof, !directed_rows[i].typed_none);

        // Chunks ahead of the real format, sometimes an extreme fmt that gets overridden.
        repeat ($urandom_range(1, 3)) put_junk_chunk($urandom_range(0, 9));
        if ($urandom_range(1) == 1)
        begin
            if ($urandom_range(1) == 1)
                put_fmt_chunk(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 0);
            else
                put_fmt_chunk(16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 0);
        end

        // The format in force for the data chunk.
        case ($urandom_range(5))
            0:       chans_cfg = 16'd0;
            1:       chans_cfg = 16'd1;
            2:       chans_cfg = 16'd2;
            3:       chans_cfg = 16'd3;
            4:       chans_cfg = 16'd6;
            default: chans_cfg = 16'hFFFF;
        endcase
        case ($urandom_range(9))
            0:       bits_cfg = 16'd1;
            1:       bits_cfg = 16'd4;
            2:       bits_cfg = 16'd8;
            3:       bits_cfg = 16'd9;
            4:       bits_cfg = 16'd12;
            5:       bits_cfg = 16'd16;
            6:       bits_cfg = 16'd17;
            7:       bits_cfg = 16'd24;
            8:       bits_cfg = 16'd32;
            default: bits_cfg = 16'd40;
        endcase
        put_fmt_chunk(16'($urandom_range(65535)), chans_cfg, $urandom, bits_cfg,
                      $urandom_range(0, 5));
        if ($urandom_range(1) == 1)
            put_junk_chunk($urandom_range(0, 9));

        // Data chunk: either used up exactly, or cut short by end-of-file.
        n_data = $urandom_range(600, 680);
        end_by_eof = 1'($urandom_range(1));
        if (!end_by_eof)
            data_len = n_data;
        else if ($urandom_range(3) == 0)
            data_len = 32'hFFFF_FFFF;
        else
            data_len = n_data + 1 + $urandom_range(0, 5000);
        put_tag(TAG_DATA);
        put_le32(data_len);
        repeat (n_data) put_byte(8'($urandom_range(255)), 1'b0, 1'b1);
        if (end_by_eof)
            put_byte(8'($urandom_range(255)), 1'b1, 1'b1);

        // Everything after the end of the stream is dropped without a result.
        repeat (4) put_byte(8'($urandom_range(255)), 1'b0, 1'b1);
        put_byte(8'($urandom_range(255)), 1'b1, 1'b1);
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d byte transfers: %0d-bit samples over %0d channels, %0d data bytes.",
                 in_count, bits_cfg, chans_cfg, n_data);
        $display("Stream ended by %s; %0d samples, %0d format and %0d error results, %0d bad.",
                 end_by_eof ? "end-of-file inside data" : "the last sample",
                 n_samples, n_formats, n_errors, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
